// File: rtl/integer_square_root_u64_top_defines.svh
// Assertion macros shared by the integer square root RTL.
`ifndef INTEGER_SQUARE_ROOT_U64_TOP_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_U64_TOP_DEFINES_SVH

// Check that a condition implies a consequence on every clock edge out of reset.
`define ISR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("isr: implication check failed");

// Check that a condition never holds on any clock edge out of reset.
`define ISR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("isr: forbidden condition seen");

`endif

// File: rtl/isr_pkg.sv
// Widths, stage record and constants for the integer square root pipeline.
package isr_pkg;

	// Operand width in use; bits of the port above it are ignored
	localparam int OPERAND_WIDTH = 64;
	// Width of the operand and result ports
	localparam int PORT_W = 64;
	// Operand padded to an even width so that each cell takes one bit pair
	localparam int PAD_W = OPERAND_WIDTH + (OPERAND_WIDTH % 2);
	// One cell per root bit
	localparam int N_STEPS = PAD_W / 2;
	localparam int ROOT_W = N_STEPS;
	// Partial remainder with room for the trial value of the last cell
	localparam int REM_W = ROOT_W + 2;

	// All-ones sentinel of the operand width
	localparam logic [OPERAND_WIDTH-1:0] VOID_CODE = '1;

	// Data handed from one cell to the next
	typedef struct packed {
		logic              is_void;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [PAD_W-1:0]  opd;
	} isr_stage_t;

endpackage

// File: rtl/isr_cell.sv
// One restoring square root cell: takes one operand bit pair and yields one root bit.
module isr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  isr_pkg::isr_stage_t in_data,
	output logic               out_valid,
	output isr_pkg::isr_stage_t out_data
);

	logic [isr_pkg::REM_W-1:0] cur;
	logic [isr_pkg::REM_W-1:0] trial;
	logic [isr_pkg::REM_W-1:0] diff;
	logic                      fits;
	isr_pkg::isr_stage_t       nxt;
	logic                      valid_s1;
	isr_pkg::isr_stage_t       data_s1;

	// Bring down the next bit pair and try the root with a one appended
	always_comb begin
		cur   = {in_data.rem[isr_pkg::REM_W-3:0], in_data.opd[isr_pkg::PAD_W-1 -: 2]};
		trial = {in_data.root, 2'b01};
		fits  = (cur >= trial);
		diff  = cur - trial;
		nxt.is_void = in_data.is_void;
		nxt.opd     = {in_data.opd[isr_pkg::PAD_W-3:0], 2'b00};
		if (fits) begin
			nxt.rem  = diff;
			nxt.root = {in_data.root[isr_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cur;
			nxt.root = {in_data.root[isr_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	// Advance the valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: rtl/integer_square_root_u64_top.sv
// Integer square root: an operand passes through the register of each cell in turn, and the root appears under done.
// Throughput one operand per cycle: a row of 32 registered cells, one root bit per cell.
// The cell chain sets the throughput; busy stays low, so start is taken on every cycle.
// Reset clears every valid mark of the chain at once; no transaction survives it.
// The result is shown for one cycle under done and cannot be stalled by the receiver.
`include "integer_square_root_u64_top_defines.svh"

module integer_square_root_u64_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [isr_pkg::PORT_W-1:0] operand,
	output logic                      done,
	output logic [isr_pkg::PORT_W-1:0] result,
	output logic                      is_void
);

	logic [isr_pkg::OPERAND_WIDTH-1:0] masked;
	logic                              accept;
	logic                [isr_pkg::N_STEPS:0] valid_chain;
	isr_pkg::isr_stage_t               head;
	isr_pkg::isr_stage_t               data_chain [isr_pkg::N_STEPS+1];
	isr_pkg::isr_stage_t               last;

	// The chain takes a new operand on every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Drop operand bits above the width and load the head of the chain
	always_comb begin
		masked       = operand[isr_pkg::OPERAND_WIDTH-1:0];
		head.is_void = (masked == isr_pkg::VOID_CODE);
		head.rem     = '0;
		head.root    = '0;
		head.opd     = isr_pkg::PAD_W'(masked);
	end
	assign data_chain[0]  = head;
	assign valid_chain[0] = accept;

	// Row of cells, one root bit each
	for (genvar i = 0; i < isr_pkg::N_STEPS; i++) begin : g_cell
		isr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[i]),
			.in_data   (data_chain[i]),
			.out_valid (valid_chain[i+1]),
			.out_data  (data_chain[i+1])
		);
	end

	// Present the root, or the sentinel for a void operand
	assign last    = data_chain[isr_pkg::N_STEPS];
	assign done    = valid_chain[isr_pkg::N_STEPS];
	assign is_void = last.is_void;
	assign result  = last.is_void ? isr_pkg::PORT_W'(isr_pkg::VOID_CODE)
	                              : isr_pkg::PORT_W'(last.root);

	// Every result goes back to an accepted transaction
	`ISR_ASSERT_IMPLY(a_done_has_start, clk, arst_n, done, $past(accept, isr_pkg::N_STEPS))
	// A void result carries the sentinel of the operand width
	`ISR_ASSERT_IMPLY(a_void_sentinel, clk, arst_n, done && is_void,
		result == isr_pkg::PORT_W'(isr_pkg::VOID_CODE))
	// A root never exceeds half the operand width
	`ISR_ASSERT_NEVER(a_root_bounded, clk, arst_n,
		done && !is_void && (result[isr_pkg::PORT_W-1:isr_pkg::ROOT_W] != '0))

endmodule
